### design/mpfd_pkg.sv
package mpfd_pkg;

    // default panel size and page height
    localparam int DEF_DISPLAY_WIDTH  = 128;
    localparam int DEF_DISPLAY_HEIGHT = 64;
    localparam int PAGE_ROWS          = 8;

    // operation codes carried in tuser
    typedef enum logic [2:0] {
        OP_PIXEL  = 3'd0,
        OP_FILL   = 3'd1,
        OP_RECT   = 3'd2,
        OP_FRAME  = 3'd3,
        OP_RRECT  = 3'd4,
        OP_RFRAME = 3'd5,
        OP_READ   = 3'd6
    } op_t;

    // control states of the top level
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_WALK,
        ST_READ
    } state_t;

    // shape handed to the walker at start
    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
        logic       edge_only;
        logic       no_corners;
    } shape_cmd_t;

    // one pixel step from the walker
    typedef struct packed {
        logic       valid;
        logic       draw;
        logic [2:0] bit_sel;
    } pix_t;

endpackage

### design/mpfd_shape_walk.sv
module mpfd_shape_walk #(
    parameter int DISPLAY_WIDTH  = mpfd_pkg::DEF_DISPLAY_WIDTH,
    parameter int DISPLAY_HEIGHT = mpfd_pkg::DEF_DISPLAY_HEIGHT,
    parameter int ADDR_W         = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mpfd_pkg::shape_cmd_t cmd,
    output mpfd_pkg::pix_t       pix,
    output logic [ADDR_W-1:0]    pix_addr
);

    mpfd_pkg::shape_cmd_t cmd_reg;
    logic [7:0] i_reg;
    logic [7:0] j_reg;
    logic       active_reg;

    logic [7:0] px;
    logic [7:0] py;
    logic       in_range;
    logic       edge_i;
    logic       edge_j;
    logic       last_i;
    logic       last_j;

    // pixel position, wrapped at 8 bits
    assign px = cmd_reg.x + i_reg;
    assign py = cmd_reg.y + j_reg;

    assign in_range = (px < 8'(DISPLAY_WIDTH)) && (py < 8'(DISPLAY_HEIGHT));
    assign last_i   = (i_reg == cmd_reg.w - 8'd1);
    assign last_j   = (j_reg == cmd_reg.h - 8'd1);
    assign edge_i   = (i_reg == 8'd0) || last_i;
    assign edge_j   = (j_reg == 8'd0) || last_j;

    // byte address, bit and draw flag of the current pixel
    always_comb
    begin
        pix.valid   = active_reg;
        pix.draw    = in_range
                    && !(cmd_reg.edge_only && !(edge_i || edge_j))
                    && !(cmd_reg.no_corners && edge_i && edge_j);
        pix.bit_sel = py[2:0];
        pix_addr    = ADDR_W'(px)
                    + ADDR_W'(py[7:3]) * ADDR_W'(DISPLAY_WIDTH);
    end

    // command capture, shape payload needs no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd;
        end
    end

    // column-major walk, rows inner
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            i_reg      <= 8'd0;
            j_reg      <= 8'd0;
        end
        else if (start)
        begin
            active_reg <= 1'b1;
            i_reg      <= 8'd0;
            j_reg      <= 8'd0;
        end
        else if (active_reg)
        begin
            if (last_j)
            begin
                j_reg <= 8'd0;
                if (last_i)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    i_reg <= i_reg + 8'd1;
                end
            end
            else
            begin
                j_reg <= j_reg + 8'd1;
            end
        end
    end

endmodule

### design/mono_page_framebuffer_draw.sv
// channel     | dir | signals                         | contents
// s_axis      | in  | tvalid tready tdata[39:0] tuser | draw or read request
// m_axis      | out | tvalid tready tdata[7:0]        | byte returned by a read
// cfg         | in  | valid ready data                | invert register
//
// a pixel draw or a shape does one pixel read-modify-write per cycle through
// the store, walking every position of the bounding box
// fill walks the store one byte a cycle
// a read waits in the read state until the output register empties or is read
// after reset the store is cleared one byte a cycle
// with no request taken; cfg writes are taken at any time
module mono_page_framebuffer_draw #(
    parameter int DISPLAY_WIDTH  = mpfd_pkg::DEF_DISPLAY_WIDTH,
    parameter int DISPLAY_HEIGHT = mpfd_pkg::DEF_DISPLAY_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x[7:0], y[15:8], color[16], rect_width[24:17], rect_height[32:25]
    input  logic [39:0] s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam int PAGES       = (DISPLAY_HEIGHT + mpfd_pkg::PAGE_ROWS - 1)
                               / mpfd_pkg::PAGE_ROWS;
    localparam int STORE_BYTES = DISPLAY_WIDTH * PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    mpfd_pkg::state_t state_reg;
    mpfd_pkg::state_t state_next;
    mpfd_pkg::op_t    in_op;

    // request fields
    logic [7:0] in_x;
    logic [7:0] in_y;
    logic       in_color;
    logic [7:0] in_w;
    logic [7:0] in_h;
    logic       in_fire;

    logic       invert_reg;

    // frame store
    logic [7:0]        store_mem [STORE_BYTES];
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              we;

    // fill sweep
    logic [ADDR_W-1:0] fill_cnt_reg;
    logic [7:0]        fill_val_reg;
    logic              fill_last;

    // read request
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              rd_ok_reg;
    logic [ADDR_W-1:0] in_addr;
    logic              in_range;

    // walker and write-back stage
    mpfd_pkg::shape_cmd_t walk_cmd;
    mpfd_pkg::pix_t       walk_pix;
    logic [ADDR_W-1:0]    walk_addr;
    logic                 walk_start;
    logic                 white_reg;
    logic                 s2_valid_reg;
    logic                 s2_draw_reg;
    logic [2:0]           s2_bit_reg;
    logic [ADDR_W-1:0]    s2_addr_reg;
    logic                 fwd_valid_reg;
    logic [ADDR_W-1:0]    fwd_addr_reg;
    logic [7:0]           fwd_data_reg;
    logic [7:0]           s2_base;
    logic [7:0]           s2_mask;
    logic [7:0]           s2_merged;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_load;

    assign in_op    = mpfd_pkg::op_t'(s_axis_tuser);
    assign in_x     = s_axis_tdata[7:0];
    assign in_y     = s_axis_tdata[15:8];
    assign in_color = s_axis_tdata[16];
    assign in_w     = s_axis_tdata[24:17];
    assign in_h     = s_axis_tdata[32:25];
    assign in_fire  = s_axis_tvalid && s_axis_tready;

    assign in_range = (in_x < 8'(DISPLAY_WIDTH)) && (in_y < 8'(DISPLAY_HEIGHT));
    assign in_addr  = ADDR_W'(in_x) + ADDR_W'(in_y[7:3]) * ADDR_W'(DISPLAY_WIDTH);

    assign fill_last = (fill_cnt_reg == ADDR_W'(STORE_BYTES - 1));

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // shape walker
    mpfd_shape_walk #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .ADDR_W         (ADDR_W)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (walk_start),
        .cmd      (walk_cmd),
        .pix      (walk_pix),
        .pix_addr (walk_addr)
    );

    // walker command from the request
    always_comb
    begin
        walk_cmd.x          = in_x;
        walk_cmd.y          = in_y;
        walk_cmd.w          = in_w;
        walk_cmd.h          = in_h;
        walk_cmd.edge_only  = (in_op == mpfd_pkg::OP_FRAME)
                            || (in_op == mpfd_pkg::OP_RFRAME);
        walk_cmd.no_corners = (in_op == mpfd_pkg::OP_RRECT)
                            || (in_op == mpfd_pkg::OP_RFRAME);
        if (in_op == mpfd_pkg::OP_PIXEL)
        begin
            walk_cmd.w = 8'd1;
            walk_cmd.h = 8'd1;
        end
    end

    // read-modify-write with forwarding of the byte written last cycle
    always_comb
    begin
        s2_base   = (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg))
                  ? fwd_data_reg : rdata_reg;
        s2_mask   = 8'd1 << s2_bit_reg;
        s2_merged = white_reg ? (s2_base | s2_mask) : (s2_base & ~s2_mask);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpfd_pkg::ST_CLEAR,
            mpfd_pkg::ST_FILL:
            begin
                if (fill_last)
                begin
                    state_next = mpfd_pkg::ST_IDLE;
                end
            end
            mpfd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_op)
                        mpfd_pkg::OP_PIXEL:
                            state_next = mpfd_pkg::ST_WALK;
                        mpfd_pkg::OP_FILL:
                            state_next = mpfd_pkg::ST_FILL;
                        mpfd_pkg::OP_RECT,
                        mpfd_pkg::OP_FRAME,
                        mpfd_pkg::OP_RRECT,
                        mpfd_pkg::OP_RFRAME:
                        begin
                            if ((in_w != 8'd0) && (in_h != 8'd0))
                            begin
                                state_next = mpfd_pkg::ST_WALK;
                            end
                        end
                        mpfd_pkg::OP_READ:
                            state_next = mpfd_pkg::ST_READ;
                        default:
                            state_next = mpfd_pkg::ST_IDLE;
                    endcase
                end
            end
            mpfd_pkg::ST_WALK:
            begin
                if (!walk_pix.valid)
                begin
                    state_next = mpfd_pkg::ST_IDLE;
                end
            end
            mpfd_pkg::ST_READ:
            begin
                if (out_load)
                begin
                    state_next = mpfd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mpfd_pkg::ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_axis_tready = 1'b0;
        walk_start    = 1'b0;
        out_load      = 1'b0;
        raddr         = in_addr;
        waddr         = s2_addr_reg;
        wdata         = s2_merged;
        we            = s2_valid_reg && s2_draw_reg;
        unique case (state_reg)
            mpfd_pkg::ST_CLEAR,
            mpfd_pkg::ST_FILL:
            begin
                waddr = fill_cnt_reg;
                wdata = fill_val_reg;
                we    = 1'b1;
            end
            mpfd_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                walk_start    = in_fire
                              && ((in_op == mpfd_pkg::OP_PIXEL)
                              || (((in_op == mpfd_pkg::OP_RECT)
                              || (in_op == mpfd_pkg::OP_FRAME)
                              || (in_op == mpfd_pkg::OP_RRECT)
                              || (in_op == mpfd_pkg::OP_RFRAME))
                              && (in_w != 8'd0) && (in_h != 8'd0)));
            end
            mpfd_pkg::ST_WALK:
            begin
                raddr = walk_addr;
            end
            mpfd_pkg::ST_READ:
            begin
                raddr    = rd_addr_reg;
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // store array, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        rdata_reg <= store_mem[raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpfd_pkg::ST_CLEAR;
            fill_cnt_reg  <= '0;
            fill_val_reg  <= 8'h00;
            invert_reg    <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s2_valid_reg  <= (state_reg == mpfd_pkg::ST_WALK) && walk_pix.valid;
            fwd_valid_reg <= we && (state_reg == mpfd_pkg::ST_WALK);
            if (cfg_valid && cfg_ready)
            begin
                invert_reg <= cfg_data;
            end
            // fill sweep counter and value
            if ((state_reg == mpfd_pkg::ST_CLEAR) || (state_reg == mpfd_pkg::ST_FILL))
            begin
                fill_cnt_reg <= fill_last ? '0 : fill_cnt_reg + ADDR_W'(1);
            end
            if (in_fire && (in_op == mpfd_pkg::OP_FILL))
            begin
                fill_val_reg <= {8{in_color}};
            end
            // output register
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s2_draw_reg  <= walk_pix.draw;
        s2_bit_reg   <= walk_pix.bit_sel;
        s2_addr_reg  <= walk_addr;
        fwd_addr_reg <= s2_addr_reg;
        fwd_data_reg <= s2_merged;
        if (in_fire)
        begin
            rd_addr_reg <= in_addr;
            rd_ok_reg   <= in_range;
            white_reg   <= ((in_op == mpfd_pkg::OP_PIXEL) ? in_color : 1'b1) ^ invert_reg;
        end
        if (out_load)
        begin
            out_data_reg <= rd_ok_reg ? rdata_reg : 8'h00;
        end
    end

endmodule

### design/mpfd_checker.sv
module mpfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // a stalled result holds its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a fill request blocks the next request
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == mpfd_pkg::OP_FILL)
        |=> !s_axis_tready)
        else $error("request taken during fill");

    // a new result only appears while a read holds the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a pending read");

    // draw requests never produce a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid
        && (s_axis_tuser != mpfd_pkg::OP_READ) |=> !m_axis_tvalid)
        else $error("result from a draw request");

endmodule

bind mono_page_framebuffer_draw mpfd_checker u_mpfd_checker (.*);
